// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL of the job queue.
// Used through `include by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("assertion failed: expected condition does not hold");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed: expected follow-up does not hold");

`endif

// ===== rtl/core/dojq_pkg.sv =====
// Package of the deadline-ordered job queue: field widths, codes, cell types.
// No dependencies.
`default_nettype none

package dojq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int TAG_W     = 8;
	localparam int STIME_W   = 32;
	localparam int TIME_W    = 33;
	localparam int OCC_W_DEF = $clog2(DEPTH_DEF + 1);

	typedef enum logic [1:0] {
		OP_INSERT   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_TICK     = 2'd2,
		OP_RESERVED = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_INSERTED   = 3'd0,
		ST_REMOVED    = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_FULL       = 3'd4,
		ST_NOT_READY  = 3'd5
	} status_t;

	typedef struct packed {
		logic              valid;
		logic [TIME_W-1:0] exec_time;
		logic [TAG_W-1:0]  tag;
	} entry_t;

	// broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              pop;
		logic [TIME_W-1:0] exec_time;
		logic [TAG_W-1:0]  tag;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/dojq_if.sv =====
// Channel interfaces of the job queue: job commands in, results out.
// Depends on dojq_pkg.
`default_nettype none

interface dojq_in_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     opcode;
	logic [dojq_pkg::TAG_W-1:0]     job_tag;
	logic [dojq_pkg::STIME_W-1:0]   submit_time;
	logic [dojq_pkg::STIME_W-1:0]   start_delay;
	logic [dojq_pkg::TIME_W-1:0]    current_time;

	modport source(output valid, opcode, job_tag, submit_time, start_delay, current_time,
		input ready);
	modport sink(input valid, opcode, job_tag, submit_time, start_delay, current_time,
		output ready);
endinterface

interface dojq_out_if #(
	parameter int OccW = dojq_pkg::OCC_W_DEF
);
	logic                         valid;
	logic                         ready;
	logic [2:0]                   status;
	logic [dojq_pkg::TAG_W-1:0]   out_tag;
	logic [dojq_pkg::TIME_W-1:0]  out_exec_time;
	logic [OccW-1:0]              occupancy;

	modport source(output valid, status, out_tag, out_exec_time, occupancy, input ready);
	modport sink(input valid, status, out_tag, out_exec_time, occupancy, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/deadline_ordered_job_queue.sv =====
// Top level of the deadline-ordered job queue: command decode, cell chain, result register.
// Depends on dojq_pkg, dojq_if, dojq_cell, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Keeps up to DEPTH jobs sorted by execution time (submit_time + start_delay)
// in a chain of DEPTH cells. Each transaction is handled in the cycle it is
// accepted: every cell compares the new time against its own entry in
// parallel and either keeps, shifts right, loads the new job, or takes its
// right neighbor on a pop. The result appears in the output register in the
// next cycle; a new transaction is accepted whenever that register is empty
// or being drained, so the queue sustains one transaction per cycle. The
// comparator per cell plus the 33-bit add at the input set the cycle time.
// No clearing pass after reset; the queue is empty at once.
module deadline_ordered_job_queue #(
	parameter int DEPTH = dojq_pkg::DEPTH_DEF,
	parameter int OccW  = $clog2(DEPTH + 1)
) (
	input wire logic clk,
	input wire logic arst_n,
	dojq_in_if.sink  in_ch,
	dojq_out_if.source out_ch
);

	dojq_pkg::entry_t entries [DEPTH+1];
	logic             shifts  [DEPTH];
	dojq_pkg::entry_t boundary;
	dojq_pkg::cmd_t   cmd;
	dojq_pkg::opcode_t op;
	dojq_pkg::status_t status_d;

	logic                          accept;
	logic                          full;
	logic                          empty;
	logic                          due;
	logic [dojq_pkg::TIME_W-1:0]   new_time;
	logic [OccW-1:0]               cnt_q;

	logic                          out_valid_q;
	dojq_pkg::status_t             status_q;
	logic [dojq_pkg::TAG_W-1:0]    tag_q;
	logic [dojq_pkg::TIME_W-1:0]   time_q;
	logic [OccW-1:0]               occ_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign op          = dojq_pkg::opcode_t'(in_ch.opcode);
	assign new_time    = {1'b0, in_ch.submit_time} + {1'b0, in_ch.start_delay};
	assign full        = (cnt_q == OccW'(DEPTH));
	assign empty       = (cnt_q == '0);
	assign due         = (entries[0].exec_time <= in_ch.current_time);

	always_comb begin
		cmd.ins       = 1'b0;
		cmd.pop       = 1'b0;
		cmd.exec_time = new_time;
		cmd.tag       = in_ch.job_tag;
		status_d      = dojq_pkg::ST_NOT_READY;
		case (op)
			dojq_pkg::OP_INSERT: begin
				if (full) begin
					status_d = dojq_pkg::ST_FULL;
				end else begin
					status_d = dojq_pkg::ST_INSERTED;
					cmd.ins  = accept;
				end
			end
			dojq_pkg::OP_REMOVE: begin
				if (empty) begin
					status_d = dojq_pkg::ST_EMPTY;
				end else begin
					status_d = dojq_pkg::ST_REMOVED;
					cmd.pop  = accept;
				end
			end
			dojq_pkg::OP_TICK: begin
				if (empty) begin
					status_d = dojq_pkg::ST_EMPTY;
				end else if (due) begin
					status_d = dojq_pkg::ST_DISPATCHED;
					cmd.pop  = accept;
				end else begin
					status_d = dojq_pkg::ST_NOT_READY;
				end
			end
			default: begin
				status_d = dojq_pkg::ST_NOT_READY;
			end
		endcase
	end

	// left of the head acts as a valid, non-shifting entry; right of the tail is empty
	always_comb begin
		boundary           = '0;
		boundary.valid     = 1'b1;
	end

	assign entries[DEPTH] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dojq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.head       ((i == 0) ? 1'b1 : 1'b0),
			.cmd        (cmd),
			.left       ((i == 0) ? boundary : entries[(i == 0) ? 0 : i-1]),
			.left_shift ((i == 0) ? 1'b0 : shifts[(i == 0) ? 0 : i-1]),
			.right      (entries[i+1]),
			.entry      (entries[i]),
			.shift      (shifts[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			tag_q    <= cmd.pop ? entries[0].tag : '0;
			time_q   <= cmd.pop ? entries[0].exec_time : '0;
			if (cmd.ins) begin
				occ_q <= cnt_q + 1'b1;
			end else if (cmd.pop) begin
				occ_q <= cnt_q - 1'b1;
			end else begin
				occ_q <= cnt_q;
			end
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.status        = status_q;
	assign out_ch.out_tag       = tag_q;
	assign out_ch.out_exec_time = time_q;
	assign out_ch.occupancy     = occ_q;

	`ASSERT_ALWAYS(a_cnt_bound, clk, arst_n, cnt_q <= OccW'(DEPTH))
	`ASSERT_ALWAYS(a_head_valid, clk, arst_n, entries[0].valid == (cnt_q != '0))
	`ASSERT_ALWAYS(a_tail_valid, clk, arst_n, entries[DEPTH-1].valid == full)
	`ASSERT_NEXT(a_pop_count, clk, arst_n, cmd.pop, cnt_q == $past(cnt_q) - 1'b1)
	`ASSERT_NEXT(a_ins_count, clk, arst_n, cmd.ins, cnt_q == $past(cnt_q) + 1'b1)

endmodule

`default_nettype wire

// ===== rtl/core/dojq_cell.sv =====
// One slot of the sorted job chain: holds an entry, shifts right on insert,
// left on pop. Depends on dojq_pkg.
`default_nettype none

module dojq_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             head,
	input  wire dojq_pkg::cmd_t   cmd,
	input  wire dojq_pkg::entry_t left,
	input  wire logic             left_shift,
	input  wire dojq_pkg::entry_t right,
	output dojq_pkg::entry_t      entry,
	output logic                  shift
);

	logic                          valid_q;
	logic [dojq_pkg::TIME_W-1:0]   time_q;
	logic [dojq_pkg::TAG_W-1:0]    tag_q;
	logic                          load_new;

	// head keeps equal times ahead of the new job
	always_comb begin
		if (head) begin
			shift = valid_q && (cmd.exec_time < time_q);
		end else begin
			shift = valid_q && (cmd.exec_time <= time_q);
		end
		load_new = left.valid && !left_shift && (shift || !valid_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right.valid;
		end else if (cmd.ins) begin
			valid_q <= valid_q || left_shift || load_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			time_q <= right.exec_time;
			tag_q  <= right.tag;
		end else if (cmd.ins && left_shift) begin
			time_q <= left.exec_time;
			tag_q  <= left.tag;
		end else if (cmd.ins && load_new) begin
			time_q <= cmd.exec_time;
			tag_q  <= cmd.tag;
		end
	end

	assign entry = {valid_q, time_q, tag_q};

endmodule

`default_nettype wire
